// ===== design/n2a_pkg.sv =====
`default_nettype none

package n2a_pkg;

  localparam logic [2:0] ACT_UDEC5 = 3'd0;
  localparam logic [2:0] ACT_UDEC3 = 3'd1;
  localparam logic [2:0] ACT_SDEC6 = 3'd2;
  localparam logic [2:0] ACT_SDEC5 = 3'd3;
  localparam logic [2:0] ACT_HEX2  = 3'd4;
  localparam logic [2:0] ACT_HEX3  = 3'd5;

  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_NINE       = 8'd57;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_X          = 8'd120;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd39;

  localparam logic [15:0] UDEC3_MAX = 16'd9999;
  localparam logic [15:0] HEX2_MAX  = 16'd255;
  localparam logic [15:0] HEX3_LIM  = 16'd4096;

  typedef enum logic [1:0] {
    KIND_SIGN = 2'd0,
    KIND_DEC  = 2'd1,
    KIND_HEX  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } result_t;

  // per-cycle character job handed from the sequencer to the output stage
  typedef struct packed {
    logic       fire;
    logic       emit;
    logic       last;
    kind_t      kind;
    logic       neg;
    logic       over;
    logic [3:0] digit;
  } step_ctl_t;

endpackage

`default_nettype wire

// ===== design/n2a_digit.sv =====
`default_nettype none

module n2a_digit (
  input  logic [16:0] rem,
  input  logic [2:0]  pos,
  output logic [3:0]  digit,
  output logic [16:0] rem_next
);
  import n2a_pkg::*;

  logic [16:0] pow;
  logic [16:0] mult;
  logic [16:0] sub;

  // rem < 10 * pow holds on entry, so the digit is the largest multiple that fits
  always_comb begin
    case (pos)
      3'd0:    pow = 17'd10000;
      3'd1:    pow = 17'd1000;
      3'd2:    pow = 17'd100;
      3'd3:    pow = 17'd10;
      default: pow = 17'd1;
    endcase
    digit = 4'd0;
    sub   = 17'd0;
    mult  = 17'd0;
    for (int d = 1; d < 10; d++) begin
      mult = pow * 17'(d);
      if (rem >= mult) begin
        digit = 4'(d);
        sub   = mult;
      end
    end
    rem_next = rem - sub;
  end

endmodule

`default_nettype wire

// ===== design/n2a_ctrl.sv =====
`default_nettype none

module n2a_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  n2a_pkg::cmd_t      cmd,
  output logic               busy,
  output n2a_pkg::step_ctl_t ctl
);
  import n2a_pkg::*;

  logic        active;
  logic [2:0]  step;
  logic [2:0]  act;
  logic [16:0] rem;
  logic        neg;
  logic        over;

  logic        accept;
  logic        act_ok;
  logic        cmd_neg;
  logic        cmd_over;
  logic [16:0] cmd_mag;
  logic [2:0]  last_step;
  logic        step_last;
  logic        is_signed;
  logic [2:0]  pos;
  logic        div_en;
  logic [3:0]  digit;
  logic [16:0] rem_next;
  logic [1:0]  nib;
  logic [15:0] hex_val;
  logic [3:0]  nibble;

  n2a_digit u_digit (
    .rem      (rem),
    .pos      (pos),
    .digit    (digit),
    .rem_next (rem_next)
  );

  // incoming command decode
  always_comb begin
    act_ok  = (cmd.action <= ACT_HEX3);
    cmd_neg = ((cmd.action == ACT_SDEC6) || (cmd.action == ACT_SDEC5)) && cmd.value[15];
    cmd_mag = cmd_neg ? (17'h10000 - {1'b0, cmd.value}) : {1'b0, cmd.value};
    unique case (cmd.action)
      ACT_UDEC3: cmd_over = (cmd.value > UDEC3_MAX);
      ACT_HEX2:  cmd_over = (cmd.value > HEX2_MAX);
      ACT_HEX3:  cmd_over = (cmd.value >= HEX3_LIM);
      default:   cmd_over = 1'b0;
    endcase
  end

  // current step decode
  always_comb begin
    unique case (act)
      ACT_UDEC5: last_step = 3'd4;
      ACT_UDEC3: last_step = 3'd4;
      ACT_SDEC6: last_step = 3'd5;
      ACT_SDEC5: last_step = 3'd4;
      ACT_HEX2:  last_step = 3'd1;
      default:   last_step = 3'd2;
    endcase
    step_last = (step == last_step);
    busy      = active && !step_last;
    accept    = start && !busy;
    is_signed = (act == ACT_SDEC6) || (act == ACT_SDEC5);

    // sdec6 spends step 0 on the sign without dividing; sdec5 drops the
    // ten-thousands digit during its sign step
    pos    = (act == ACT_SDEC6) ? (step - 3'd1) : step;
    div_en = (act <= ACT_SDEC5) && !((act == ACT_SDEC6) && (step == 3'd0));

    nib     = (act == ACT_HEX2) ? 2'(3'd1 - step) : 2'(3'd2 - step);
    hex_val = rem[15:0];
    nibble  = hex_val[{nib, 2'b00} +: 4];

    ctl.fire = active;
    ctl.last = step_last;
    ctl.emit = !((act == ACT_UDEC3) && (step < 3'd2));
    ctl.neg  = neg;
    ctl.over = over;
    if (act >= ACT_HEX2) begin
      ctl.kind  = KIND_HEX;
      ctl.digit = nibble;
    end else if (is_signed && (step == 3'd0)) begin
      ctl.kind  = KIND_SIGN;
      ctl.digit = digit;
    end else begin
      ctl.kind  = KIND_DEC;
      ctl.digit = digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 3'd0;
    end else if (accept) begin
      active <= act_ok;
      step   <= 3'd0;
    end else if (active) begin
      if (step_last) begin
        active <= 1'b0;
      end
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= cmd.action;
      rem  <= cmd_mag;
      neg  <= cmd_neg;
      over <= cmd_over;
    end else if (active && div_en) begin
      rem <= rem_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    (accept && act_ok) |=> (active && (step == 3'd0)))
    else $error("accepted command did not start at step zero");

  a_step_advance : assert property (@(posedge clk) disable iff (rst)
    (active && !step_last) |=> (active && (step == 3'($past(step) + 3'd1))))
    else $error("step sequence broke mid transaction");

  a_step_bound : assert property (@(posedge clk) disable iff (rst)
    active |-> (step <= last_step))
    else $error("step ran past the final character");
`endif

endmodule

`default_nettype wire

// ===== design/number_to_ascii_formatter.sv =====
`default_nettype none

// Formats a 16-bit value as ASCII text, one character per cycle.
// Command channel: cmd (action, value) is taken on a rising edge with start
// high and busy low. Actions 6 and 7 are taken and produce nothing.
// Result channel: result (character, last) is valid for exactly one cycle
// while strobe is high; last marks the final character of a transaction.
// The receiver cannot stall, so characters leave back to back.
// The accepting edge loads the sequencer; each character is then decoded
// from the sequencer step and registered onto the result ports with strobe.
// Throughput: one character per cycle, apart from the silent steps in which
// udec3 drops its two high digits. A transaction gives six characters for
// sdec6, five for udec5 and sdec5, three for udec3 and hex3 and two for hex2.
// The decimal digit extractor handles one digit position per cycle.
// busy drops on the final step, so the next command is taken while the
// last character of the previous one is being registered.
// Reset: synchronous; clears the sequencer and the strobe, any transaction
// in flight is dropped.

module number_to_ascii_formatter (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  n2a_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             strobe,
  output n2a_pkg::result_t result
);
  import n2a_pkg::*;

  step_ctl_t  ctl;
  logic [7:0] ch;
  logic [7:0] dec_ch;
  logic [7:0] hex_ch;

  n2a_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .ctl   (ctl)
  );

  always_comb begin
    dec_ch = CH_ZERO + {4'd0, ctl.digit};
    hex_ch = dec_ch;
    if (dec_ch > CH_NINE) begin
      hex_ch = dec_ch + HEX_ALPHA_OFS;
    end
    case (ctl.kind)
      KIND_SIGN: ch = ctl.neg ? CH_MINUS : CH_ZERO;
      KIND_DEC:  ch = ctl.over ? CH_X : dec_ch;
      KIND_HEX:  ch = ctl.over ? CH_X : hex_ch;
      default:   ch = CH_X;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.fire && ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.emit) begin
      result.character <= ch;
      result.last      <= ctl.last;
    end
  end

`ifndef SYNTHESIS
  a_chars_contiguous : assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe)
    else $error("gap inside a transaction's characters");

  a_text_continues : assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> ctl.fire)
    else $error("sequencer idle before the final character");
`endif

endmodule

`default_nettype wire
